// ----- hw/rtl/lwsl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lwsl_pkg: shared types for the longest window sum block
// Controller states, command and status bundles and fixed field widths.
// ----------------------------------------------------------------------------
package lwsl_pkg;

    localparam int IN_VALUE_W = 16;
    localparam int LIMIT_W    = 32;
    localparam int SUM_W      = 33;
    localparam int LEN_W      = 11;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT,
        ST_ADD,
        ST_CHECK,
        ST_SHRINK
    } state_t;

    typedef struct packed {
        logic take;
        logic push_in;
        logic push_held;
        logic pop;
        logic mark_ovf;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic over;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/longest_window_sum_within_limit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// longest_window_sum_within_limit: longest run with sum at or below a limit
// Two-pointer sliding window over a stream of unsigned values.
// ----------------------------------------------------------------------------
// Each input word passes through the idle and check states when nothing leaves
// the window, plus a shrink and a check for every element dropped to bring
// the sum to or under sum_limit, plus evict and add states when the store
// already holds DEPTH elements; every element is dropped at most once. The
// store has a single read port with registered read data, which supplies
// each dropped element ahead of its subtraction. One word is processed at a
// time; a finished result waits in the output register while the next word
// is taken, and the check state waits while that register still holds an
// unaccepted result. No clearing pass runs after reset. Write sum_limit only while the block is idle.
// ----------------------------------------------------------------------------
module longest_window_sum_within_limit #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [lwsl_pkg::IN_DATA_W-1:0]     s_tdata,  // [15:0] value
    input  wire logic                               s_tlast,  // last
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [lwsl_pkg::OUT_DATA_W-1:0]         m_tdata,  // [10:0] window_length,
                                                              // [21:11] best_length,
                                                              // [22] overflow, [23] zero
    output logic                                    m_tlast,  // end_of_set
    input  wire logic                               sum_limit_we,
    input  wire logic [lwsl_pkg::LIMIT_W-1:0]       sum_limit_wdata
);

    lwsl_pkg::cmd_t            cmd;
    lwsl_pkg::sts_t            sts;
    logic [lwsl_pkg::LEN_W-1:0] window_length;
    logic [lwsl_pkg::LEN_W-1:0] best_length;
    logic                       overflow;

    lwsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lwsl_dp #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_value          (s_tdata[lwsl_pkg::IN_VALUE_W-1:0]),
        .in_last           (s_tlast),
        .sum_limit_we      (sum_limit_we),
        .sum_limit_wdata   (sum_limit_wdata),
        .cmd               (cmd),
        .sts               (sts),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .out_window_length (window_length),
        .out_best_length   (best_length),
        .out_overflow      (overflow),
        .out_end_of_set    (m_tlast)
    );

    assign m_tdata = {1'b0, overflow, best_length, window_length};

endmodule
`default_nettype wire

// ----- hw/rtl/lwsl_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lwsl_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lwsl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/lwsl_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lwsl_ctrl: sequencing state machine
// Accepts one word, evicts on a full store, shrinks the window, emits.
// ----------------------------------------------------------------------------
module lwsl_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire lwsl_pkg::sts_t sts,
    output lwsl_pkg::cmd_t     cmd
);

    lwsl_pkg::state_t state_reg;
    lwsl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lwsl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lwsl_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sts.full ? lwsl_pkg::ST_EVICT : lwsl_pkg::ST_CHECK;
                end
            end
            lwsl_pkg::ST_EVICT:  state_next = lwsl_pkg::ST_ADD;
            lwsl_pkg::ST_ADD:    state_next = lwsl_pkg::ST_CHECK;
            lwsl_pkg::ST_CHECK:
            begin
                if (sts.over)
                begin
                    state_next = lwsl_pkg::ST_SHRINK;
                end
                else if (sts.out_free)
                begin
                    state_next = lwsl_pkg::ST_IDLE;
                end
            end
            lwsl_pkg::ST_SHRINK: state_next = lwsl_pkg::ST_CHECK;
            default:             state_next = lwsl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            lwsl_pkg::ST_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.take     = s_tvalid;
                cmd.push_in  = s_tvalid & ~sts.full;
            end
            lwsl_pkg::ST_EVICT:
            begin
                cmd.pop      = 1'b1;
                cmd.mark_ovf = 1'b1;
            end
            lwsl_pkg::ST_ADD:
            begin
                cmd.push_held = 1'b1;
            end
            lwsl_pkg::ST_CHECK:
            begin
                cmd.emit = ~sts.over & sts.out_free;
            end
            lwsl_pkg::ST_SHRINK:
            begin
                cmd.pop = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lwsl_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lwsl_dp: window datapath
// Ring store, head and tail pointers, window count and sum, best length,
// overflow flag, limit register and result register.
// ----------------------------------------------------------------------------
module lwsl_dp #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [lwsl_pkg::IN_VALUE_W-1:0]  in_value,
    input  wire logic                             in_last,
    input  wire logic                             sum_limit_we,
    input  wire logic [lwsl_pkg::LIMIT_W-1:0]     sum_limit_wdata,
    input  wire lwsl_pkg::cmd_t                   cmd,
    output lwsl_pkg::sts_t                        sts,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic [lwsl_pkg::LEN_W-1:0]            out_window_length,
    output logic [lwsl_pkg::LEN_W-1:0]            out_best_length,
    output logic                                  out_overflow,
    output logic                                  out_end_of_set
);

    localparam int SW = (VALUE_BITS < lwsl_pkg::IN_VALUE_W) ? VALUE_BITS
                                                             : lwsl_pkg::IN_VALUE_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = lwsl_pkg::LEN_W;

    logic [AW-1:0]                 head_reg, head_next;
    logic [AW-1:0]                 tail_reg, tail_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [lwsl_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [CW-1:0]                 best_reg, best_next;
    logic                          ovf_reg, ovf_next;
    logic [lwsl_pkg::LIMIT_W-1:0]  limit_reg;
    logic [SW-1:0]                 held_value_reg;
    logic                          held_last_reg;
    logic                          out_valid_reg;
    logic [LW-1:0]                 out_wlen_reg;
    logic [LW-1:0]                 out_best_reg;
    logic                          out_ovf_reg;
    logic                          out_eos_reg;

    logic                          ram_we;
    logic [SW-1:0]                 ram_wdata;
    logic [SW-1:0]                 ram_rdata;
    logic [CW-1:0]                 best_cand;
    logic [CW+LW-1:0]              count_ext;
    logic [CW+LW-1:0]              best_ext;

    assign ram_we    = cmd.push_in | cmd.push_held;
    assign ram_wdata = cmd.push_in ? in_value[SW-1:0] : held_value_reg;

    lwsl_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (ram_wdata),
        .raddr (tail_reg),
        .rdata (ram_rdata)
    );

    assign sts.full     = (count_reg == CW'(DEPTH));
    assign sts.over     = (sum_reg > lwsl_pkg::SUM_W'(limit_reg)) && (count_reg != '0);
    assign sts.out_free = ~out_valid_reg | out_ready;

    assign best_cand = (count_reg > best_reg) ? count_reg : best_reg;
    assign count_ext = {{LW{1'b0}}, count_reg};
    assign best_ext  = {{LW{1'b0}}, best_cand};

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        best_next  = best_reg;
        ovf_next   = ovf_reg;
        if (cmd.pop)
        begin
            tail_next  = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg - 1'b1;
            sum_next   = sum_reg - lwsl_pkg::SUM_W'(ram_rdata);
        end
        if (cmd.mark_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (ram_we)
        begin
            head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + lwsl_pkg::SUM_W'(ram_wdata);
        end
        if (cmd.emit)
        begin
            best_next = best_cand;
            if (held_last_reg)
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
                sum_next   = '0;
                best_next  = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            best_reg  <= best_next;
            ovf_reg   <= ovf_next;
            if (sum_limit_we)
            begin
                limit_reg <= sum_limit_wdata;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            held_value_reg <= in_value[SW-1:0];
            held_last_reg  <= in_last;
        end
        if (cmd.emit)
        begin
            out_wlen_reg <= count_ext[LW-1:0];
            out_best_reg <= best_ext[LW-1:0];
            out_ovf_reg  <= ovf_reg;
            out_eos_reg  <= held_last_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_window_length = out_wlen_reg;
    assign out_best_length   = out_best_reg;
    assign out_overflow      = out_ovf_reg;
    assign out_end_of_set    = out_eos_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("window count above store depth");

    a_emit_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (sum_reg <= lwsl_pkg::SUM_W'(limit_reg)))
        else $error("result emitted with window sum above limit");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (count_reg != '0))
        else $error("drop from empty window");

    a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && held_last_reg) |=> (count_reg == '0 && sum_reg == '0 && !ovf_reg))
        else $error("state not cleared after end of set");

endmodule
`default_nettype wire
